// ----- src/lhps_pkg.sv -----
// ----------------------------------------------------------------------------
// Latency histogram statistics package
// Sizes, field widths, codes and reset values shared by the interfaces,
// the core and its checker.
// ----------------------------------------------------------------------------
package lhps_pkg;

    // Store sizes
    localparam int NUM_CLASSES = 8;
    localparam int NUM_BUCKETS = 16;

    // Field widths fixed by the channel definitions
    localparam int IN_CLS_W  = 4;
    localparam int CNT_W     = 32;
    localparam int BYTE_W    = 64;
    localparam int LAT_W     = 32;
    localparam int PCT_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int ADDR_W  = CLS_W + BKT_W;
    localparam int MEM_DEPTH = NUM_CLASSES << BKT_W;
    localparam int POS_W   = $clog2(LAT_W);
    localparam int PROD_W  = CNT_W + PCT_W;
    localparam int RUN_W   = PROD_W + BKT_W;

    // Class limit, one bit wider than the class field
    localparam logic [IN_CLS_W:0] CLS_LIMIT = (IN_CLS_W + 1)'(NUM_CLASSES);

    // Highest bucket, highest class and the scale of a percent
    localparam logic [POS_W-1:0] TOP_POS    = POS_W'(NUM_BUCKETS - 1);
    localparam logic [BKT_W-1:0] TOP_BUCKET = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [CLS_W-1:0] TOP_CLASS  = CLS_W'(NUM_CLASSES - 1);
    localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(100);

    // Input kinds
    localparam logic KIND_RECORD   = 1'b0;
    localparam logic KIND_SNAPSHOT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [PCT_W-1:0] LOW_PCT_RESET  = PCT_W'(50);
    localparam logic [PCT_W-1:0] HIGH_PCT_RESET = PCT_W'(99);

endpackage

// ----- src/lhps_if.sv -----
// ----------------------------------------------------------------------------
// Latency histogram statistics channels
// Valid/ready channels for records and snapshot requests, for class
// results, and for configuration writes.
// ----------------------------------------------------------------------------
interface lhps_rec_if import lhps_pkg::*;;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [IN_CLS_W-1:0] class_id;
    logic [CNT_W-1:0]    byte_len;
    logic [LAT_W-1:0]    latency_usec;
    logic                error_flag;

    modport source (output valid, kind, class_id, byte_len, latency_usec, error_flag,
                    input ready);
    modport sink   (input valid, kind, class_id, byte_len, latency_usec, error_flag,
                    output ready);
endinterface

interface lhps_res_if import lhps_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IN_CLS_W-1:0] result_class;
    logic [CNT_W-1:0]    op_count;
    logic [BYTE_W-1:0]   byte_total;
    logic [LAT_W-1:0]    low_pct_usec;
    logic [LAT_W-1:0]    high_pct_usec;
    logic [CNT_W-1:0]    error_total;
    logic                last;

    modport source (output valid, result_class, op_count, byte_total, low_pct_usec,
                           high_pct_usec, error_total, last,
                    input ready);
    modport sink   (input valid, result_class, op_count, byte_total, low_pct_usec,
                          high_pct_usec, error_total, last,
                    output ready);
endinterface

interface lhps_cfg_if import lhps_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PCT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/latency_histogram_percentile_stats_core.sv -----
// Record: one halving a cycle in the latency register to find floor(log2(latency)),
//   then a read and a write of the bucket store.
// Snapshot: per class two threshold multiplies, then per bucket a read, a multiply
//   on the shared multiplier, an accumulate and a compare; then a load and an output.
// One transaction is in work at a time; input ready is high only when idle.
// Synchronous active-low reset clears all counters and the bucket valid bits at once.
// ----------------------------------------------------------------------------
// Latency histogram percentile statistics core
// Per-class operation, byte and log2 latency histogram counters with a
// snapshot that reports two percentile latencies for every class.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_stats_core import lhps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lhps_rec_if.sink    i_rec,
    lhps_res_if.source  o_res,
    lhps_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOG, S_RD, S_WR,
        S_MLO, S_MHI, S_BRD, S_BMUL, S_BACC, S_BCMP, S_LOAD, S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic [PCT_W-1:0] r_low_pct;
    logic [PCT_W-1:0] r_high_pct;

    // Per-class counters
    logic [CNT_W-1:0]  r_ops   [NUM_CLASSES];
    logic [BYTE_W-1:0] r_bytes [NUM_CLASSES];
    logic [CNT_W-1:0]  r_err_cnt;

    // Bucket store and its valid bits
    logic [CNT_W-1:0]     mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    // Working registers
    logic [CLS_W-1:0]  r_cls;
    logic [BKT_W-1:0]  r_bkt;
    logic [LAT_W-1:0]  r_lat;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_len;
    logic              r_err;
    logic [PROD_W-1:0] r_thr_lo;
    logic [PROD_W-1:0] r_thr_hi;
    logic [PROD_W-1:0] r_scaled;
    logic [RUN_W-1:0]  r_run;
    logic              r_lo_found;
    logic              r_hi_found;
    logic [BKT_W-1:0]  r_lo_bkt;
    logic [BKT_W-1:0]  r_hi_bkt;

    // Output register
    logic                r_out_valid;
    logic [IN_CLS_W-1:0] r_out_cls;
    logic [CNT_W-1:0]    r_out_ops;
    logic [BYTE_W-1:0]   r_out_bytes;
    logic [LAT_W-1:0]    r_out_lo;
    logic [LAT_W-1:0]    r_out_hi;
    logic [CNT_W-1:0]    r_out_err;
    logic                r_out_last;

    logic              in_acc;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  rd_eff;
    logic              mem_wr;
    logic [CNT_W-1:0]  mul_a;
    logic [PCT_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  cur_ops;

    assign i_rec.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_rec.valid && i_rec.ready;

    assign addr    = {r_cls, r_bkt};
    assign rd_eff  = r_rd_vld ? r_rd_data : '0;
    assign mem_wr  = (r_state == S_WR);
    assign cur_ops = r_ops[r_cls];

    // Shared multiplier: op count times a percentile, or a bucket count times one hundred
    always_comb begin
        mul_a = cur_ops;
        mul_b = PCT_SCALE;
        case (r_state)
            S_MLO:   mul_b = r_low_pct;
            S_MHI:   mul_b = r_high_pct;
            S_BMUL:  mul_a = rd_eff;
            default: ;
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Bucket store: one read-modify-write port
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[addr] <= rd_eff + CNT_W'(1);
        end
        r_rd_data <= mem[addr];
    end

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low_pct   <= LOW_PCT_RESET;
            r_high_pct  <= HIGH_PCT_RESET;
            r_err_cnt   <= '0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_ops[c]   <= '0;
                r_bytes[c] <= '0;
            end
        end else begin
            r_rd_vld <= r_vld[addr];

            // Configuration writes; unknown indexes are dropped
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_LOW_PCT:  r_low_pct  <= i_cfg.data;
                    REG_HIGH_PCT: r_high_pct <= i_cfg.data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lat <= i_rec.latency_usec;
                        r_len <= i_rec.byte_len;
                        r_err <= i_rec.error_flag;
                        r_pos <= '0;
                        if (i_rec.kind == KIND_SNAPSHOT) begin
                            r_cls   <= '0;
                            r_state <= S_MLO;
                        end else if ({1'b0, i_rec.class_id} < CLS_LIMIT) begin
                            r_cls   <= CLS_W'(i_rec.class_id);
                            r_state <= S_LOG;
                        end
                    end
                end

                // One halving a cycle to find floor(log2(latency))
                S_LOG: begin
                    if (r_lat > LAT_W'(1)) begin
                        r_lat <= r_lat >> 1;
                        r_pos <= r_pos + POS_W'(1);
                    end else begin
                        r_bkt   <= (r_pos > TOP_POS) ? TOP_BUCKET : BKT_W'(r_pos);
                        r_state <= S_RD;
                    end
                end

                S_RD: begin
                    r_state <= S_WR;
                end

                // Bucket write happens in the store block; update the class counters
                S_WR: begin
                    r_vld[addr]    <= 1'b1;
                    r_ops[r_cls]   <= cur_ops + CNT_W'(1);
                    r_bytes[r_cls] <= r_bytes[r_cls] + BYTE_W'(r_len);
                    if (r_err) begin
                        r_err_cnt <= r_err_cnt + CNT_W'(1);
                    end
                    r_state <= S_IDLE;
                end

                // Thresholds in hundredths: total * pct, at least one
                S_MLO: begin
                    r_thr_lo <= (prod == '0) ? PROD_W'(1) : prod;
                    r_state  <= S_MHI;
                end

                S_MHI: begin
                    r_thr_hi   <= (prod == '0) ? PROD_W'(1) : prod;
                    r_run      <= '0;
                    r_bkt      <= '0;
                    r_lo_found <= 1'b0;
                    r_hi_found <= 1'b0;
                    r_lo_bkt   <= TOP_BUCKET;
                    r_hi_bkt   <= TOP_BUCKET;
                    r_state    <= S_BRD;
                end

                S_BRD: begin
                    r_state <= S_BMUL;
                end

                S_BMUL: begin
                    r_scaled <= prod;
                    r_state  <= S_BACC;
                end

                S_BACC: begin
                    r_run   <= r_run + RUN_W'(r_scaled);
                    r_state <= S_BCMP;
                end

                // The running sum times one hundred reaches total * pct
                S_BCMP: begin
                    if (!r_lo_found && (r_run >= RUN_W'(r_thr_lo))) begin
                        r_lo_found <= 1'b1;
                        r_lo_bkt   <= r_bkt;
                    end
                    if (!r_hi_found && (r_run >= RUN_W'(r_thr_hi))) begin
                        r_hi_found <= 1'b1;
                        r_hi_bkt   <= r_bkt;
                    end
                    if (r_bkt == TOP_BUCKET) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_bkt   <= r_bkt + BKT_W'(1);
                        r_state <= S_BRD;
                    end
                end

                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_out_cls   <= IN_CLS_W'(r_cls);
                    r_out_ops   <= cur_ops;
                    r_out_bytes <= r_bytes[r_cls];
                    r_out_lo    <= (cur_ops == '0) ? '0 : (LAT_W'(1) << r_lo_bkt);
                    r_out_hi    <= (cur_ops == '0) ? '0 : (LAT_W'(1) << r_hi_bkt);
                    r_out_err   <= r_err_cnt;
                    r_out_last  <= (r_cls == TOP_CLASS);
                    r_state     <= S_OUT;
                end

                S_OUT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cls   <= r_cls + CLS_W'(1);
                            r_state <= S_MLO;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_class  = r_out_cls;
    assign o_res.op_count      = r_out_ops;
    assign o_res.byte_total    = r_out_bytes;
    assign o_res.low_pct_usec  = r_out_lo;
    assign o_res.high_pct_usec = r_out_hi;
    assign o_res.error_total   = r_out_err;
    assign o_res.last          = r_out_last;

endmodule

// ----- src/lhps_checker.sv -----
// ----------------------------------------------------------------------------
// Latency histogram statistics checker
// Port-level checks on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module lhps_checker import lhps_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_last,
    input logic [CNT_W-1:0] i_out_ops,
    input logic [LAT_W-1:0] i_out_lo,
    input logic [LAT_W-1:0] i_out_hi
);

    // A stalled result transaction holds its valid, op count, percentile latencies and last flag
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_ops)
            && $stable(i_out_lo) && $stable(i_out_hi) && $stable(i_out_last)))
        else $error("result transaction changed while stalled");

    // No new transaction is taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // After the last result of a snapshot the output goes quiet
    a_last_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> !i_out_valid)
        else $error("result presented after the last of a snapshot");

    // An empty class reports zero latencies
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_ops == '0)) |-> ((i_out_lo == '0) && (i_out_hi == '0)))
        else $error("empty class reported a percentile latency");

    // Percentile latencies are zero or a power of two
    a_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($onehot0(i_out_lo) && $onehot0(i_out_hi)))
        else $error("percentile latency is not a power of two");

endmodule

bind latency_histogram_percentile_stats_core lhps_checker u_lhps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_last  (o_res.last),
    .i_out_ops   (o_res.op_count),
    .i_out_lo    (o_res.low_pct_usec),
    .i_out_hi    (o_res.high_pct_usec)
);

// ----- sim/lhps_stats_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Latency histogram statistics checker
// Watches the record, result and configuration channels of the statistics
// core, keeps its own copy of the per-class counters and histograms, works
// out the class results of every snapshot and compares each result
// transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lhps_stats_checker import lhps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lhps_rec_if  i_rec,
    lhps_res_if  i_res,
    lhps_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);

    // Cap on printed mismatch lines so that a broken core cannot flood the log
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [IN_CLS_W-1:0] result_class;
        logic [CNT_W-1:0]    op_count;
        logic [BYTE_W-1:0]   byte_total;
        logic [LAT_W-1:0]    low_pct_usec;
        logic [LAT_W-1:0]    high_pct_usec;
        logic [CNT_W-1:0]    error_total;
        logic                last;
    } t_class_stats;

    // Predicted state of the core
    logic [CNT_W-1:0]  op_cnt   [NUM_CLASSES];
    logic [BYTE_W-1:0] byte_cnt [NUM_CLASSES];
    logic [CNT_W-1:0]  hist     [NUM_CLASSES][NUM_BUCKETS];
    logic [CNT_W-1:0]  err_cnt;
    logic [PCT_W-1:0]  low_pct;
    logic [PCT_W-1:0]  high_pct;

    t_class_stats expected_stats[$];
    int           mismatches = 0;

    // Histogram bucket of a latency: position of its highest set bit,
    // zero for latencies of zero and one, clamped to the top bucket.
    function automatic int latency_bucket(input logic [LAT_W-1:0] lat);
        int pos;
        pos = 0;
        for (int i = 0; i < LAT_W; i++) begin
            if (lat[i]) pos = i;
        end
        if (pos > NUM_BUCKETS - 1) pos = NUM_BUCKETS - 1;
        return pos;
    endfunction

    // Power-of-two latency at which the cumulative histogram of a class first
    // reaches the given percentage of its operations. The goal is formed at
    // 64 bits and is never below one; a goal never reached gives the top bucket.
    function automatic logic [LAT_W-1:0] class_pct_latency(input int cls,
                                                           input logic [PCT_W-1:0] pct);
        logic [63:0] total;
        logic [63:0] goal;
        logic [63:0] running;
        total   = 64'(op_cnt[cls]);
        running = '0;
        if (total == 0) return '0;
        goal = (total * pct + PCT_SCALE - 1) / PCT_SCALE;
        if (goal == 0) goal = 1;
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            running += 64'(hist[cls][b]);
            if (running >= goal) return LAT_W'(1) << b;
        end
        return LAT_W'(1) << TOP_BUCKET;
    endfunction

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Track configuration, records and snapshots; check every result transaction
    always @(posedge i_clk) begin
        t_class_stats want;
        int           cls;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                op_cnt[c]   = '0;
                byte_cnt[c] = '0;
                for (int b = 0; b < NUM_BUCKETS; b++) hist[c][b] = '0;
            end
            err_cnt  = '0;
            low_pct  = LOW_PCT_RESET;
            high_pct = HIGH_PCT_RESET;
            expected_stats.delete();
        end else begin
            // Result transactions are checked against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual class %0d",
                                 $time, i_res.result_class);
                end else begin
                    want = expected_stats.pop_front();
                    compare_field("result_class", 64'(want.result_class),
                                  64'(i_res.result_class));
                    compare_field("op_count", 64'(want.op_count), 64'(i_res.op_count));
                    compare_field("byte_total", want.byte_total, i_res.byte_total);
                    compare_field("low_pct_usec", 64'(want.low_pct_usec),
                                  64'(i_res.low_pct_usec));
                    compare_field("high_pct_usec", 64'(want.high_pct_usec),
                                  64'(i_res.high_pct_usec));
                    compare_field("error_total", 64'(want.error_total),
                                  64'(i_res.error_total));
                    compare_field("last", 64'(want.last), 64'(i_res.last));
                end
            end

            // Register writes; unknown indexes leave everything as it was
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LOW_PCT: begin
                        low_pct = i_cfg.data;
                    end
                    REG_HIGH_PCT: begin
                        high_pct = i_cfg.data;
                    end
                    default: begin
                    end
                endcase
            end

            // Input transactions: a record updates the counters of its class,
            // a snapshot produces one prediction per class
            if (i_rec.valid && i_rec.ready) begin
                if (i_rec.kind == KIND_RECORD) begin
                    if ({1'b0, i_rec.class_id} < CLS_LIMIT) begin
                        cls = int'(i_rec.class_id);
                        op_cnt[cls]   = op_cnt[cls] + 1'b1;
                        byte_cnt[cls] = byte_cnt[cls] + BYTE_W'(i_rec.byte_len);
                        hist[cls][latency_bucket(i_rec.latency_usec)] =
                            hist[cls][latency_bucket(i_rec.latency_usec)] + 1'b1;
                        if (i_rec.error_flag) err_cnt = err_cnt + 1'b1;
                    end
                end else begin
                    for (int c = 0; c < NUM_CLASSES; c++) begin
                        want.result_class  = IN_CLS_W'(c);
                        want.op_count      = op_cnt[c];
                        want.byte_total    = byte_cnt[c];
                        want.low_pct_usec  = class_pct_latency(c, low_pct);
                        want.high_pct_usec = class_pct_latency(c, high_pct);
                        want.error_total   = err_cnt;
                        want.last          = (c == NUM_CLASSES - 1);
                        expected_stats.push_back(want);
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_stats.size();
    end

endmodule

// ----- sim/latency_histogram_percentile_stats_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Latency histogram percentile statistics core testbench
// Drives records and snapshot requests with random gaps on both sides,
// programs the two percentile registers between phases while the core is
// idle, and relies on the checker for the expected class results.
// ----------------------------------------------------------------------------
module latency_histogram_percentile_stats_core_tb;
    import lhps_pkg::*;

    // Spare register indexes that the core must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    // A record keeps the core busy after acceptance while it halves the latency and updates the store
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 72;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   errors;
    int   pending;
    int   stall_cycles;

    lhps_rec_if rec_ch ();
    lhps_res_if res_ch ();
    lhps_cfg_if cfg_ch ();

    latency_histogram_percentile_stats_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    lhps_stats_checker u_stats_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (rec_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    // Result back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one input transaction, after a random gap, and wait for it to be taken
    task automatic send_item(input logic kind, input logic [IN_CLS_W-1:0] cls,
                             input logic [CNT_W-1:0] bytes, input logic [LAT_W-1:0] lat,
                             input logic err);
        if ($urandom_range(99) < send_idle_pct) begin
            rec_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        rec_ch.valid        <= 1'b1;
        rec_ch.kind         <= kind;
        rec_ch.class_id     <= cls;
        rec_ch.byte_len     <= bytes;
        rec_ch.latency_usec <= lat;
        rec_ch.error_flag   <= err;
        do @(posedge i_clk); while (!rec_ch.ready);
    endtask

    // Snapshot request with random content in the fields it ignores
    task automatic take_snapshot();
        send_item(KIND_SNAPSHOT, IN_CLS_W'($urandom), $urandom, $urandom, 1'($urandom));
    endtask

    // Wait until every predicted result has arrived and the core has gone quiet
    task automatic quiesce();
        rec_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PCT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic configure(input logic [PCT_W-1:0] low, input logic [PCT_W-1:0] high);
        write_reg(REG_LOW_PCT, low);
        write_reg(REG_HIGH_PCT, high);
        cfg_ch.valid <= 1'b0;
    endtask

    // One phase of random traffic: mostly records with random content over
    // all histogram buckets, some out-of-range classes, and snapshots
    task automatic run_phase(input int sidle, input int ridle, input logic [PCT_W-1:0] low,
                             input logic [PCT_W-1:0] high);
        int                  left;
        logic [IN_CLS_W-1:0] cls;
        logic [LAT_W-1:0]    lat;
        logic [CNT_W-1:0]    bytes;
        left          = PHASE_ITEMS;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        configure(low, high);
        while (left > 0) begin
            // Now and then hold back until the core has delivered everything
            if ($urandom_range(19) == 0) begin
                rec_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if ($urandom_range(7) == 0) begin
                take_snapshot();
                left--;
            end else begin
                if ($urandom_range(9) == 0)
                    cls = IN_CLS_W'($urandom_range(15, NUM_CLASSES));
                else
                    cls = IN_CLS_W'($urandom_range(NUM_CLASSES - 1));
                lat   = ($urandom_range(15) == 0) ? '0 : $urandom >> $urandom_range(LAT_W - 1);
                bytes = ($urandom_range(7) == 0) ? '1 : $urandom;
                send_item(KIND_RECORD, cls, bytes, lat, $urandom_range(3) == 0);
                if ({1'b0, cls} < CLS_LIMIT) left--;
            end
        end
        take_snapshot();
        quiesce();
    endtask

    // Stimulus
    initial begin
        rec_ch.valid        <= 1'b0;
        rec_ch.kind         <= KIND_RECORD;
        rec_ch.class_id     <= '0;
        rec_ch.byte_len     <= '0;
        rec_ch.latency_usec <= '0;
        rec_ch.error_flag   <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_LOW_PCT;
        cfg_ch.data         <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 81;

        // Snapshot of empty classes at the reset percentiles
        take_snapshot();

        // Latency extremes, bucket edges, byte carries and ignored classes
        send_item(KIND_RECORD, 0, '0, '0, 1'b0);
        send_item(KIND_RECORD, 0, '1, 1, 1'b0);
        send_item(KIND_RECORD, 1, '1, 2, 1'b1);
        send_item(KIND_RECORD, 1, '1, '1, 1'b1);
        send_item(KIND_RECORD, IN_CLS_W'(NUM_CLASSES - 1), 32'h1234, 32'h8000, 1'b0);
        send_item(KIND_RECORD, IN_CLS_W'(NUM_CLASSES - 1), 5, 32'h7FFF, 1'b0);
        send_item(KIND_RECORD, IN_CLS_W'(NUM_CLASSES), '1, 4, 1'b1);
        send_item(KIND_RECORD, '1, '1, '1, 1'b1);
        send_item(KIND_RECORD, 2, '1, 100, 1'b0);
        send_item(KIND_RECORD, 2, '1, 200, 1'b0);
        send_item(KIND_RECORD, 3, 7, 3, 1'b1);

        // Snapshot with every ignored field at its maximum
        send_item(KIND_SNAPSHOT, '1, '1, '1, 1'b1);
        quiesce();

        // Percentile extremes: zero and one hundred
        configure(0, 100);
        take_snapshot();
        quiesce();

        // Percentiles above one hundred fall through to the top bucket
        configure('1, 101);
        take_snapshot();
        quiesce();

        // Writes to spare indexes must leave both percentiles alone
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        cfg_ch.valid <= 1'b0;
        take_snapshot();
        quiesce();

        run_phase(31, 81, PCT_W'($urandom_range(100)), PCT_W'($urandom_range(100)));
        run_phase(81, 31, PCT_W'($urandom_range(100)), PCT_W'($urandom_range(127, 101)));
        run_phase(0, 0, LOW_PCT_RESET, HIGH_PCT_RESET);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: too long without any accepted transaction ends the run
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
